// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define LTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lease table check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define LTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lease table check failed");

`endif

// ===== src/lte_pkg.sv =====
`timescale 1ns / 1ps

package lte_pkg;

  localparam int DEF_USER_BITS  = 10;
  localparam int DEF_EPOCH_BITS = 48;

  // Fixed field widths of the stream payload.
  localparam int CMD_W     = 2;
  localparam int USER_W    = 10;
  localparam int GW_W      = 16;
  localparam int CONN_W    = 32;
  localparam int TIME_W    = 48;
  localparam int EPOCH_W   = 48;
  localparam int ERR_W     = 3;
  localparam int TTL_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W   = 160;
  localparam int OUT_TUSER_W = 5;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(30000);

  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TTL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_MODE = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLAIM   = 2'd0,
    CMD_RENEW   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_LOCATE  = 2'd3
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_DEP_UNAV  = 3'd1,
    ERR_NOT_FOUND = 3'd2,
    ERR_NOT_EPOCH = 3'd3,
    ERR_EXHAUSTED = 3'd4
  } err_e;

endpackage

// ===== src/lte_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents.
module lte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lease_table_with_epochs.sv =====
`timescale 1ns / 1ps

// Lease table with fencing epochs, addressed directly by the user index.
// Commands arrive on the slave stream (command in tuser) and each one
// produces exactly one result transfer on the master stream. The block
// accepts one command per clock cycle while the master side does not stall
// the result register: the transfer edge starts the read of the table entry
// from the lease RAM and loads the read stage, the block then decides the
// command, and the edge that passes it on writes the entry back and loads
// the result register. A command that follows one on the same entry
// sees the freshly written contents through a one-entry bypass, so
// back-to-back commands on one user need no gaps. After reset the block
// runs a clearing pass over the RAM, one entry per cycle, covering all
// 2**USER_BITS entries (1024 by default); tready stays low until it is done,
// while configuration writes are taken at any time. Configuration is meant
// to change only while no command is in flight.
module lease_table_with_epochs #(
  parameter int USER_BITS  = lte_pkg::DEF_USER_BITS,
  parameter int EPOCH_BITS = lte_pkg::DEF_EPOCH_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [lte_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lte_pkg::TTL_W-1:0]         cfg_data_i,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: user_index, gateway_in, connection_in, epoch_in,
  // now_ms, then zero fill.
  input  logic [lte_pkg::TDATA_W-1:0]       s_axis_tdata,
  // Fields from bit 0 up: command.
  input  logic [lte_pkg::CMD_W-1:0]         s_axis_tuser,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: epoch_out, expires_out, gateway_out,
  // connection_out, user_out, then zero fill.
  output logic [lte_pkg::TDATA_W-1:0]       m_axis_tdata,
  // Fields from bit 0 up: ok, error_code, expired_flag.
  output logic [lte_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  localparam int USER_W  = lte_pkg::USER_W;
  localparam int GW_W    = lte_pkg::GW_W;
  localparam int CONN_W  = lte_pkg::CONN_W;
  localparam int TIME_W  = lte_pkg::TIME_W;
  localparam int EPOCH_W = lte_pkg::EPOCH_W;
  localparam int TTL_W   = lte_pkg::TTL_W;
  localparam int DEPTH   = 2 ** USER_BITS;
  localparam int UEXT_W  = USER_BITS + USER_W;
  localparam int CMP_W   = (EPOCH_BITS > EPOCH_W) ? EPOCH_BITS : EPOCH_W;

  // Table word layout from bit 0 up: expiry, epoch, connection, gateway, valid.
  localparam int EXP_LO   = 0;
  localparam int EPO_LO   = EXP_LO + TIME_W;
  localparam int CONN_LO  = EPO_LO + EPOCH_BITS;
  localparam int GW_LO    = CONN_LO + CONN_W;
  localparam int VALID_B  = GW_LO + GW_W;
  localparam int WORD_W   = VALID_B + 1;

  // Input payload offsets.
  localparam int IN_USER_LO = 0;
  localparam int IN_GW_LO   = IN_USER_LO + USER_W;
  localparam int IN_CONN_LO = IN_GW_LO + GW_W;
  localparam int IN_EPO_LO  = IN_CONN_LO + CONN_W;
  localparam int IN_NOW_LO  = IN_EPO_LO + EPOCH_W;

  // Configuration registers.
  logic [TTL_W-1:0] ttl_q;
  logic             fail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q  <= lte_pkg::TTL_RESET;
      fail_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lte_pkg::CFG_LEASE_TTL: ttl_q  <= cfg_data_i;
        lte_pkg::CFG_FAIL_MODE: fail_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clearing pass: walk every entry once after reset and write it invalid.
  logic                 clear_q;
  logic [USER_BITS-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else if (clear_q) begin
      clr_addr_q <= clr_addr_q + USER_BITS'(1);
      if (clr_addr_q == {USER_BITS{1'b1}}) begin
        clear_q <= 1'b0;
      end
    end
  end

  // Handshake between the read stage and the result register.
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_fire;
  logic in_accept;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clear_q && (!s1_valid_q || s1_fire);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  logic [USER_W-1:0]    in_user;
  logic [UEXT_W-1:0]    in_user_ext;
  logic [USER_BITS-1:0] in_idx;

  assign in_user     = s_axis_tdata[IN_USER_LO +: USER_W];
  assign in_user_ext = UEXT_W'(in_user);
  assign in_idx      = in_user_ext[USER_BITS-1:0];

  // Read stage: the command waits here while its entry comes out of the RAM.
  lte_pkg::cmd_e        s1_cmd_q;
  logic [USER_W-1:0]    s1_user_q;
  logic [USER_BITS-1:0] s1_idx_q;
  logic [GW_W-1:0]      s1_gw_q;
  logic [CONN_W-1:0]    s1_conn_q;
  logic [EPOCH_W-1:0]   s1_epoch_q;
  logic [TIME_W-1:0]    s1_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q   <= lte_pkg::cmd_e'(s_axis_tuser);
      s1_user_q  <= in_user;
      s1_idx_q   <= in_idx;
      s1_gw_q    <= s_axis_tdata[IN_GW_LO +: GW_W];
      s1_conn_q  <= s_axis_tdata[IN_CONN_LO +: CONN_W];
      s1_epoch_q <= s_axis_tdata[IN_EPO_LO +: EPOCH_W];
      s1_now_q   <= s_axis_tdata[IN_NOW_LO +: TIME_W];
    end
  end

  // Lease RAM. The decide stage is the only writer besides the clearing pass.
  logic                 wr_en;
  logic [WORD_W-1:0]    wr_data;
  logic                 ram_we;
  logic [USER_BITS-1:0] ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;

  assign ram_we    = clear_q || wr_en;
  assign ram_waddr = clear_q ? clr_addr_q : s1_idx_q;
  assign ram_wdata = clear_q ? '0 : wr_data;

  lte_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // The RAM returns old data when the entry is written on the same edge as
  // it is read; in that case the written word is kept here and used instead.
  logic              byp_hit_q;
  logic [WORD_W-1:0] byp_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (in_accept) begin
      byp_hit_q <= wr_en && (s1_idx_q == in_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byp_data_q <= wr_data;
    end
  end

  logic [WORD_W-1:0]     entry;
  logic                  e_valid;
  logic [GW_W-1:0]       e_gw;
  logic [CONN_W-1:0]     e_conn;
  logic [EPOCH_BITS-1:0] e_epoch;
  logic [TIME_W-1:0]     e_expiry;

  assign entry    = byp_hit_q ? byp_data_q : ram_rdata;
  assign e_valid  = entry[VALID_B];
  assign e_gw     = entry[GW_LO +: GW_W];
  assign e_conn   = entry[CONN_LO +: CONN_W];
  assign e_epoch  = entry[EPO_LO +: EPOCH_BITS];
  assign e_expiry = entry[EXP_LO +: TIME_W];

  // Global epoch counter; the all-ones value is never handed out.
  logic [EPOCH_BITS-1:0] next_epoch_q;
  logic                  epoch_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_epoch_q <= EPOCH_BITS'(1);
    end else if (epoch_step) begin
      next_epoch_q <= next_epoch_q + EPOCH_BITS'(1);
    end
  end

  // Decide stage.
  logic [TIME_W:0]   exp_sum;
  logic [TIME_W-1:0] new_expiry;
  logic              live;
  logic              epoch_match;
  logic              exhausted;

  assign exp_sum     = {1'b0, s1_now_q} + (TIME_W + 1)'(ttl_q);
  assign new_expiry  = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
  assign live        = e_valid && (s1_now_q < e_expiry);
  assign epoch_match = CMP_W'(e_epoch) == CMP_W'(s1_epoch_q);
  assign exhausted   = next_epoch_q == {EPOCH_BITS{1'b1}};

  logic                 res_ok;
  lte_pkg::err_e        res_err;
  logic                 res_expired;
  logic [EPOCH_W-1:0]   res_epoch;
  logic [TIME_W-1:0]    res_expires;
  logic [GW_W-1:0]      res_gw;
  logic [CONN_W-1:0]    res_conn;
  logic [USER_W-1:0]    res_user;
  logic                 do_write;
  logic                 do_step;

  always_comb begin
    res_ok      = 1'b0;
    res_err     = lte_pkg::ERR_NONE;
    res_expired = 1'b0;
    res_epoch   = '0;
    res_expires = '0;
    res_gw      = '0;
    res_conn    = '0;
    res_user    = '0;
    do_write    = 1'b0;
    do_step     = 1'b0;
    wr_data     = entry;
    if (fail_q) begin
      res_err = lte_pkg::ERR_DEP_UNAV;
    end else begin
      case (s1_cmd_q)
        lte_pkg::CMD_CLAIM: begin
          if (exhausted) begin
            res_err = lte_pkg::ERR_EXHAUSTED;
          end else begin
            res_ok    = 1'b1;
            res_epoch = EPOCH_W'(next_epoch_q);
            do_write  = 1'b1;
            do_step   = 1'b1;
            wr_data   = {1'b1, s1_gw_q, s1_conn_q, next_epoch_q, new_expiry};
          end
        end
        lte_pkg::CMD_LOCATE: begin
          if (!live) begin
            res_err     = lte_pkg::ERR_NOT_FOUND;
            res_expired = e_valid;
          end else begin
            res_ok    = 1'b1;
            res_epoch = EPOCH_W'(e_epoch);
            res_gw    = e_gw;
            res_conn  = e_conn;
            res_user  = s1_user_q;
          end
        end
        lte_pkg::CMD_RENEW, lte_pkg::CMD_RELEASE: begin
          if (!live) begin
            res_err = lte_pkg::ERR_NOT_FOUND;
          end else if (!epoch_match) begin
            res_err = lte_pkg::ERR_NOT_EPOCH;
          end else begin
            res_ok   = 1'b1;
            do_write = 1'b1;
            if (s1_cmd_q == lte_pkg::CMD_RENEW) begin
              res_expires = new_expiry;
              wr_data     = {1'b1, e_gw, e_conn, e_epoch, new_expiry};
            end else begin
              wr_data     = {1'b0, e_gw, e_conn, e_epoch, e_expiry};
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign wr_en      = s1_fire && do_write;
  assign epoch_step = s1_fire && do_step;

  // Result register; it holds while the master side stalls.
  logic [lte_pkg::TDATA_W-1:0]     out_data_q;
  logic [lte_pkg::OUT_TUSER_W-1:0] out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= lte_pkg::TDATA_W'({res_user, res_conn, res_gw, res_expires, res_epoch});
      out_user_q <= {res_expired, res_err, res_ok};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== src/lte_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks of the lease table result stream.
module lte_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lte_pkg::TDATA_W-1:0]     m_axis_tdata,
  input logic [lte_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  logic                      res_ok;
  logic [lte_pkg::ERR_W-1:0] res_err;
  logic                      res_expired;

  assign res_ok      = m_axis_tuser[0];
  assign res_err     = m_axis_tuser[3:1];
  assign res_expired = m_axis_tuser[4];

  // A stalled result stays on the bus unchanged.
  `LTE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Success and an error code never come together.
  `LTE_ASSERT_NOW(a_ok_no_err, clk_i, rst_ni, m_axis_tvalid && res_ok, res_err == lte_pkg::ERR_NONE)

  // A failed command always names its reason.
  `LTE_ASSERT_NOW(a_fail_has_err, clk_i, rst_ni, m_axis_tvalid && !res_ok, res_err != lte_pkg::ERR_NONE)

  // The expired flag only accompanies a not-found answer, and a failed
  // command carries no route or epoch.
  `LTE_ASSERT_NOW(a_expired_not_found, clk_i, rst_ni, m_axis_tvalid && res_expired, res_err == lte_pkg::ERR_NOT_FOUND)
  `LTE_ASSERT_NOW(a_fail_zero_data, clk_i, rst_ni, m_axis_tvalid && !res_ok, m_axis_tdata == '0)

endmodule

bind lease_table_with_epochs lte_checker u_lte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/lease_table_with_epochs_tb.sv =====
`timescale 1ns / 1ps

module lease_table_with_epochs_tb;
  import lte_pkg::*;

  // Generous ceiling: the clearing pass, every item with its longest gaps on
  // both sides, and the long output stall, taken many times over.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    cmd_e                op;
    logic [USER_W-1:0]   user;
    logic [GW_W-1:0]     gw;
    logic [CONN_W-1:0]   conn;
    logic [EPOCH_W-1:0]  epoch;
    logic [TIME_W-1:0]   now;
  } lease_req_t;

  typedef struct packed {
    logic                ok;
    err_e                err;
    logic                expired;
    logic [EPOCH_W-1:0]  epoch;
    logic [TIME_W-1:0]   expires;
    logic [GW_W-1:0]     gw;
    logic [CONN_W-1:0]   conn;
    logic [USER_W-1:0]   user;
  } lease_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = CFG_LEASE_TTL;
  logic [TTL_W-1:0]       cfg_data = '0;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // Fields from bit 0 up: user_index, gateway_in, connection_in, epoch_in,
  // now_ms, then zero fill.
  logic [TDATA_W-1:0]     s_tdata = '0;
  // Fields from bit 0 up: command.
  logic [CMD_W-1:0]       s_tuser = '0;

  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // Fields from bit 0 up: epoch_out, expires_out, gateway_out,
  // connection_out, user_out, then zero fill.
  logic [TDATA_W-1:0]     m_tdata;
  // Fields from bit 0 up: ok, error_code, expired_flag.
  logic [OUT_TUSER_W-1:0] m_tuser;

  lease_table_with_epochs uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Commands waiting to be offered, and the replies owed by the block.
  lease_req_t   cmd_q[$];
  lease_reply_t reply_q[$];
  int           open_cnt = 0;
  int           reply_cnt = 0;
  int           errs = 0;
  bit           calm = 1'b0;

  // Shadow of the lease table and its registers, advanced once per accepted
  // command transfer.
  bit               tbl_valid  [1 << USER_W];
  bit [GW_W-1:0]    tbl_gw     [1 << USER_W];
  bit [CONN_W-1:0]  tbl_conn   [1 << USER_W];
  bit [EPOCH_W-1:0] tbl_epoch  [1 << USER_W];
  bit [TIME_W-1:0]  tbl_expiry [1 << USER_W];
  bit [EPOCH_W-1:0] epoch_ctr = 1;
  bit [TTL_W-1:0]   ttl_ms = TTL_RESET;
  bit               fail_on = 1'b0;

  // Stimulus side bookkeeping: the epoch each user should hold, so that most
  // renew and release commands present a matching one.
  bit [EPOCH_W-1:0] gen_epoch [1 << USER_W];
  bit [EPOCH_W-1:0] gen_ctr = 1;
  bit [TIME_W-1:0]  gen_now = '0;
  bit [USER_W-1:0]  hot_users [16];

  function automatic lease_reply_t lease_outcome(input lease_req_t rq);
    lease_reply_t     r;
    logic [TIME_W:0]  sum;
    logic [TIME_W-1:0] new_expiry;
    logic             live;
    r = '0;
    sum = {1'b0, rq.now} + (TIME_W + 1)'(ttl_ms);
    new_expiry = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    live = tbl_valid[rq.user] && (rq.now < tbl_expiry[rq.user]);
    if (fail_on) begin
      r.err = ERR_DEP_UNAV;
      return r;
    end
    case (rq.op)
      CMD_CLAIM: begin
        if (epoch_ctr == '1) begin
          r.err = ERR_EXHAUSTED;
        end else begin
          tbl_valid[rq.user]  = 1'b1;
          tbl_gw[rq.user]     = rq.gw;
          tbl_conn[rq.user]   = rq.conn;
          tbl_epoch[rq.user]  = epoch_ctr;
          tbl_expiry[rq.user] = new_expiry;
          r.ok    = 1'b1;
          r.epoch = epoch_ctr;
          epoch_ctr = epoch_ctr + 1'b1;
        end
      end
      CMD_LOCATE: begin
        if (!live) begin
          r.err     = ERR_NOT_FOUND;
          r.expired = tbl_valid[rq.user];
        end else begin
          r.ok    = 1'b1;
          r.epoch = tbl_epoch[rq.user];
          r.gw    = tbl_gw[rq.user];
          r.conn  = tbl_conn[rq.user];
          r.user  = rq.user;
        end
      end
      default: begin
        if (!live) begin
          r.err = ERR_NOT_FOUND;
        end else if (tbl_epoch[rq.user] != rq.epoch) begin
          r.err = ERR_NOT_EPOCH;
        end else if (rq.op == CMD_RENEW) begin
          tbl_expiry[rq.user] = new_expiry;
          r.ok      = 1'b1;
          r.expires = new_expiry;
        end else begin
          tbl_valid[rq.user] = 1'b0;
          r.ok = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic add_req(input cmd_e op, input logic [USER_W-1:0] usr,
                         input logic [GW_W-1:0] gw, input logic [CONN_W-1:0] conn,
                         input logic [EPOCH_W-1:0] ep, input logic [TIME_W-1:0] tnow);
    lease_req_t rq;
    rq.op = op;
    rq.user = usr;
    rq.gw = gw;
    rq.conn = conn;
    rq.epoch = ep;
    rq.now = tnow;
    if (op == CMD_CLAIM && !fail_on) begin
      gen_epoch[usr] = gen_ctr;
      gen_ctr = gen_ctr + 1'b1;
    end
    open_cnt++;
    cmd_q.push_back(rq);
  endtask

  // Random commands aimed mostly at a small set of users, so that claims,
  // renewals and releases meet each other; time creeps forward by up to
  // step_max per command, with the odd wild timestamp thrown in.
  task automatic gen_random(input int count, input int unsigned step_max);
    int unsigned     pick;
    cmd_e            op;
    logic [USER_W-1:0] usr;
    logic [EPOCH_W-1:0] ep;
    logic [TIME_W-1:0] tnow;
    logic [TIME_W:0] sum;
    for (int i = 0; i < 16; i++) hot_users[i] = USER_W'($urandom);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      usr = (pick < 85) ? hot_users[$urandom_range(0, 15)] : USER_W'($urandom);
      pick = $urandom_range(0, 99);
      op = (pick < 30) ? CMD_CLAIM : (pick < 55) ? CMD_RENEW :
           (pick < 70) ? CMD_RELEASE : CMD_LOCATE;
      sum = {1'b0, gen_now} + (TIME_W + 1)'($urandom_range(0, step_max));
      gen_now = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      tnow = ($urandom_range(0, 19) == 0) ? rand48() : gen_now;
      pick = $urandom_range(0, 9);
      ep = (pick < 8) ? gen_epoch[usr] : (pick == 8) ? gen_epoch[usr] + 1'b1 : rand48();
      if (op == CMD_CLAIM || op == CMD_LOCATE) ep = rand48();
      add_req(op, usr, GW_W'($urandom), $urandom, ep, tnow);
    end
  endtask

  // Waits until every reply owed has come back, then lets the pipeline settle.
  task automatic wait_idle();
    while (open_cnt > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TTL_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_LEASE_TTL) ttl_ms = val;
    else fail_on = val[0];
  endtask

  task automatic check_field(input string fname, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      if (errs < 10)
        $display("reply %0d: %s expected %0h got %0h", reply_cnt, fname, want_v, got_v);
      errs++;
    end
  endtask

  // Command sender: holds a transfer until it is taken, then either moves on
  // to the next queued command or sits out a short random gap.
  always @(posedge clk_i or negedge rst_ni) begin : send_proc
    lease_req_t cur;
    int         gap_left;
    bit         busy;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        reply_q.push_back(lease_outcome(cur));
        busy = 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 8);
      end
      if (!busy) begin
        if (gap_left > 0 && !calm) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, cur.now, cur.epoch, cur.conn, cur.gw, cur.user};
          s_tuser  <= cur.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply receiver: compares each reply transfer with the oldest owed one and
  // throttles tready, including one long hold that backs the block up.
  always @(posedge clk_i or negedge rst_ni) begin : recv_proc
    lease_reply_t got, want;
    int           hold_left;
    bit           long_hold_done;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.ok      = m_tuser[0];
        got.err     = err_e'(m_tuser[3:1]);
        got.expired = m_tuser[4];
        got.epoch   = m_tdata[47:0];
        got.expires = m_tdata[95:48];
        got.gw      = m_tdata[111:96];
        got.conn    = m_tdata[143:112];
        got.user    = m_tdata[153:144];
        reply_cnt++;
        open_cnt--;
        if (reply_q.size() == 0) begin
          if (errs < 10) $display("reply %0d arrived with nothing owed", reply_cnt);
          errs++;
        end else begin
          want = reply_q.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("error_code", want.err, got.err);
          check_field("expired_flag", want.expired, got.expired);
          check_field("epoch_out", want.epoch, got.epoch);
          check_field("expires_out", want.expires, got.expires);
          check_field("gateway_out", want.gw, got.gw);
          check_field("connection_out", want.conn, got.conn);
          check_field("user_out", want.user, got.user);
        end
      end
      if (hold_left > 0 && !calm) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && reply_cnt >= 700) begin
        long_hold_done = 1'b1;
        hold_left = 400;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    int unsigned cycles;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [EPOCH_W-1:0] ep_old;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass with a short lease: misses on an empty entry, the full
    // claim, renew and release life cycle with wrong and right epochs, the
    // expiry boundary, saturation of the expiry at the top of time, and
    // back-to-back claims on one user.
    write_reg(CFG_LEASE_TTL, 32'd1000);
    write_reg(CFG_FAIL_MODE, 32'd0);
    add_req(CMD_LOCATE, 0, 0, 0, 0, 100);
    add_req(CMD_RENEW, 0, 0, 0, 1, 100);
    add_req(CMD_CLAIM, 0, 0, 0, TIME_MAX, 100);
    add_req(CMD_LOCATE, 0, 0, 0, 0, 200);
    add_req(CMD_RENEW, 0, 0, 0, gen_epoch[0] + 1'b1, 300);
    add_req(CMD_RENEW, 0, 0, 0, gen_epoch[0], 500);
    add_req(CMD_RELEASE, 0, 0, 0, gen_epoch[0] + 48'd4, 600);
    add_req(CMD_RELEASE, 0, 0, 0, gen_epoch[0], 700);
    add_req(CMD_LOCATE, 0, 0, 0, 0, 800);
    add_req(CMD_CLAIM, 1023, 16'hFFFF, 32'hFFFF_FFFF, 0, 1000);
    add_req(CMD_LOCATE, 1023, 0, 0, 0, 1999);
    add_req(CMD_LOCATE, 1023, 0, 0, 0, 2000);
    add_req(CMD_RENEW, 1023, 0, 0, gen_epoch[1023], 2000);
    add_req(CMD_RELEASE, 1023, 0, 0, gen_epoch[1023], 2500);
    add_req(CMD_CLAIM, 1023, 16'h1234, 32'h89AB_CDEF, 0, TIME_MAX - 48'd500);
    add_req(CMD_RENEW, 1023, 0, 0, gen_epoch[1023], TIME_MAX - 48'd1);
    add_req(CMD_LOCATE, 1023, 0, 0, 0, TIME_MAX);
    add_req(CMD_CLAIM, 5, 16'h00A5, 32'h5A5A_0001, TIME_MAX, 0);
    ep_old = gen_epoch[5];
    add_req(CMD_CLAIM, 5, 16'h5A00, 32'h0000_A5A5, 0, 10);
    add_req(CMD_RENEW, 5, 0, 0, ep_old, 20);
    add_req(CMD_RENEW, 5, 0, 0, gen_epoch[5], 30);
    add_req(CMD_LOCATE, 5, 0, 0, 0, 40);
    wait_idle();

    // Zero lease: every claim is dead on arrival.
    write_reg(CFG_LEASE_TTL, 32'd0);
    gen_now = 48'd5000;
    gen_random(150, 3);
    wait_idle();

    // Longest lease near the top of time, so expiries start to saturate.
    write_reg(CFG_LEASE_TTL, 32'hFFFF_FFFF);
    gen_now = 48'hFFFE_F000_0000;
    gen_random(200, 1 << 22);
    wait_idle();

    // Dependency outage: everything answers unavailable and nothing changes.
    write_reg(CFG_FAIL_MODE, 32'd1);
    write_reg(CFG_LEASE_TTL, 32'd7);
    gen_random(100, 100);
    wait_idle();

    // Main run with a moderate lease; the sender then pauses until every
    // reply is in, and the tail runs with both sides at full rate.
    write_reg(CFG_FAIL_MODE, 32'd0);
    write_reg(CFG_LEASE_TTL, 32'd5000);
    gen_now = 48'd1_000_000;
    gen_random(1100, 400);
    wait_idle();
    calm = 1'b1;
    gen_random(280, 400);
    wait_idle();
    repeat (8) @(posedge clk_i);

    errs += reply_q.size();
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
